// File: rtl/core/lirs_pkg.sv
// lirs_pkg: shared widths, constants and sequencer states for the
// linear interpolation resampler. No dependencies; used by every file
// in rtl/core.
package lirs_pkg;

  localparam int SAMPLE_W   = 16;             // signed sample width
  localparam int FRAC_W     = 16;             // fraction bits of the read phase
  localparam int STEP_W     = 21;             // step register width
  localparam int PHASE_W    = STEP_W + 1;     // working phase, room for one advance
  localparam int DIFF_W     = SAMPLE_W + 1;   // cur - prev
  localparam int PROD_W     = DIFF_W + FRAC_W + 1;
  localparam int MAX_OUT    = 16;             // most results per input word
  localparam int CNT_W      = $clog2(MAX_OUT + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = STEP_W;

  localparam logic [PHASE_W-1:0] PHASE_ONE  = PHASE_W'(1) << FRAC_W;
  localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(1) << FRAC_W;
  localparam logic [CNT_W-1:0]   CNT_MAX    = CNT_W'(MAX_OUT);

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 2'd1;

  typedef enum logic [1:0] {
    S_IDLE,   // waiting for an input word
    S_MUL,    // shared multiplier takes diff * frac
    S_ADD,    // add to previous sample, load output register
    S_OUT     // result word offered downstream
  } lirs_state_t;

endpackage

// File: rtl/core/lirs_interp_unit.sv
// lirs_interp_unit: the shared multiply unit of the resampler.
// Registers diff * frac, then forms base + floor(product / 2^FRAC_W).
// Depends on lirs_pkg.
module lirs_interp_unit (
  input  logic                                 clk,
  input  logic                                 load,
  input  logic signed [lirs_pkg::DIFF_W-1:0]   diff_i,
  input  logic        [lirs_pkg::FRAC_W-1:0]   frac_i,
  input  logic signed [lirs_pkg::SAMPLE_W-1:0] base_i,
  output logic signed [lirs_pkg::SAMPLE_W-1:0] val_o
);
  import lirs_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [DIFF_W-1:0] step_s;
  logic signed [DIFF_W-1:0] sum_s;

  // fraction is unsigned, so it goes in with a zero sign bit
  assign prod_nxt = PROD_W'(diff_i) * PROD_W'($signed({1'b0, frac_i}));

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
    end
  end

  // arithmetic shift by taking the upper bits gives floor rounding
  assign step_s = prod_r[FRAC_W +: DIFF_W];
  assign sum_s  = DIFF_W'(base_i) + step_s;
  // the result lies between prev and cur, so it fits the sample width
  assign val_o  = sum_s[SAMPLE_W-1:0];

endmodule

// File: rtl/core/linear_interpolation_resampler_unit.sv
// linear_interpolation_resampler_unit: top level of the mono linear
// interpolation sample rate converter. Depends on lirs_pkg and
// lirs_interp_unit.
//
// Usage:
//   in_*  : one signed 16-bit source sample per word.
//   out_* : interpolated 16-bit samples; out_tlast marks the final result
//           that an input word produces (zero to sixteen results per word).
//   cfg_* : bypass (index 0) and step_q16 (index 1, unsigned Q5.16 source
//           over target rate); write only while the block is idle.
// Sequence: an input word is taken in S_IDLE; each result then passes the
//   shared multiplier through S_MUL (multiply), S_ADD (add) and S_OUT
//   (present), and S_OUT waits while out_tready is held low. The first
//   sample after reset and a word whose phase has already reached one are
//   taken in S_IDLE alone and give no result. Bypass goes from S_IDLE
//   straight to S_OUT and gives one result.
// in_tready is high only while no word is in work, so one word is handled
//   at a time. When the receiver stalls, the result stays in the output
//   register and the sequencer waits. Reset (synchronous, active low) clears
//   the phase, previous sample and state, and the config registers to defaults.
module linear_interpolation_resampler_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // in_tdata: [15:0] in_sample
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [15:0]                            in_tdata,
  // out_tdata: [15:0] out_sample
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [15:0]                            out_tdata,
  output logic                                   out_tlast,
  input  logic                                   cfg_we,
  input  logic [lirs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lirs_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import lirs_pkg::*;

  lirs_state_t state_r, state_nxt;

  logic                       bypass_r;
  logic [STEP_W-1:0]          step_r;
  logic                       have_prev_r, have_prev_nxt;
  logic [PHASE_W-1:0]         phase_r, phase_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       byp_r, byp_nxt;
  logic signed [SAMPLE_W-1:0] prev_r, prev_nxt;
  logic signed [SAMPLE_W-1:0] cur_r, cur_nxt;
  logic signed [DIFF_W-1:0]   diff_r, diff_nxt;
  logic [SAMPLE_W-1:0]        out_data_r, out_data_nxt;
  logic                       out_last_r, out_last_nxt;

  logic                       in_acc, out_acc;
  logic                       mul_load;
  logic signed [SAMPLE_W-1:0] in_sample_s;
  logic signed [SAMPLE_W-1:0] interp_val;
  logic                       phase_ge_one;
  logic [PHASE_W-1:0]         phase_wrapped;

  assign in_sample_s   = $signed(in_tdata);
  assign in_acc        = in_tvalid && in_tready;
  assign out_acc       = out_tvalid && out_tready;
  assign phase_ge_one  = (phase_r >= PHASE_ONE);
  assign phase_wrapped = phase_ge_one ? (phase_r - PHASE_ONE) : '0;

  lirs_interp_unit u_interp (
    .clk    (clk),
    .load   (mul_load),
    .diff_i (diff_r),
    .frac_i (phase_r[FRAC_W-1:0]),
    .base_i (prev_r),
    .val_o  (interp_val)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r <= 1'b0;
      step_r   <= STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BYPASS: bypass_r <= cfg_data[0];
        CFG_STEP:   step_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (bypass_r) begin
            state_nxt = S_OUT;
          end else if (have_prev_r && !phase_ge_one) begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: state_nxt = S_ADD;
      S_ADD: state_nxt = S_OUT;
      S_OUT: begin
        if (out_tready) begin
          state_nxt = out_last_r ? S_IDLE : S_MUL;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    in_tready     = (state_r == S_IDLE);
    out_tvalid    = (state_r == S_OUT);
    mul_load      = (state_r == S_MUL);
    have_prev_nxt = have_prev_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    byp_nxt       = byp_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    diff_nxt      = diff_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          byp_nxt = bypass_r;
          cnt_nxt = '0;
          cur_nxt = in_sample_s;
          if (bypass_r) begin
            out_data_nxt = in_tdata;
            out_last_nxt = 1'b1;
          end else if (!have_prev_r) begin
            prev_nxt      = in_sample_s;
            have_prev_nxt = 1'b1;
            phase_nxt     = '0;
          end else if (phase_ge_one) begin
            // source word skipped: no result
            phase_nxt = phase_r - PHASE_ONE;
            prev_nxt  = in_sample_s;
          end else begin
            diff_nxt = DIFF_W'(in_sample_s) - DIFF_W'(prev_r);
          end
        end
      end
      S_MUL: begin
        // multiplier samples the current fraction; advance afterwards
        phase_nxt = phase_r + PHASE_W'(step_r);
        cnt_nxt   = cnt_r + CNT_W'(1);
      end
      S_ADD: begin
        out_data_nxt = interp_val;
        out_last_nxt = phase_ge_one || (cnt_r == CNT_MAX);
      end
      S_OUT: begin
        if (out_tready && out_last_r && !byp_r) begin
          phase_nxt = phase_wrapped;
          prev_nxt  = cur_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      have_prev_r <= 1'b0;
      phase_r     <= '0;
      prev_r      <= '0;
      cnt_r       <= '0;
      byp_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      have_prev_r <= have_prev_nxt;
      phase_r     <= phase_nxt;
      prev_r      <= prev_nxt;
      cnt_r       <= cnt_nxt;
      byp_r       <= byp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    diff_r     <= diff_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tdata = out_data_r;
  assign out_tlast = out_last_r;

  // no new word is taken while a result word waits downstream
  a_no_accept_while_pending: assert property (
    @(posedge clk) disable iff (!rst_n) in_acc |-> !out_tvalid)
    else $error("input word accepted while a result is pending");

  // result count never passes the per-word limit
  a_cnt_bound: assert property (
    @(posedge clk) disable iff (!rst_n) cnt_r <= CNT_MAX)
    else $error("result count above limit");

  // a non-final interpolated result leaves the phase below one
  a_phase_continue: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast && !byp_r) |-> (phase_r < PHASE_ONE))
    else $error("loop continues with phase at or above one");

  // after the final result the block is ready for the next word
  a_ready_after_last: assert property (
    @(posedge clk) disable iff (!rst_n) (out_acc && out_tlast) |=> in_tready)
    else $error("not ready after final result word");

  // the multiplier only ever sees a fraction below one
  a_frac_below_one: assert property (
    @(posedge clk) disable iff (!rst_n) mul_load |-> !phase_ge_one)
    else $error("multiplier loaded with phase at or above one");

endmodule

// File: dv/tb_linear_interpolation_resampler_unit.sv
// tb_linear_interpolation_resampler_unit: self-checking testbench for the
// linear interpolation resampler; a scoreboard class predicts each result word.
// Depends on lirs_pkg and linear_interpolation_resampler_unit only.
module tb_linear_interpolation_resampler_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import lirs_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int SETTLE_CYCLES  = 64;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int CHUNKS         = 12;
  localparam int CHUNK_WORDS    = 30;
  localparam int REPORT_MAX     = 10;

  // indexes past the two registers, which the block must ignore
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam logic [STEP_W-1:0] STEP_SIXTEENTH = STEP_W'(4096);
  localparam logic [STEP_W-1:0] STEP_TINY      = STEP_W'(3000);
  localparam logic [STEP_W-1:0] STEP_ONE_HALF  = STEP_W'(98304);
  localparam logic [STEP_W-1:0] STEP_SIXTEEN   = STEP_W'(1048576);

  typedef struct packed {
    logic [SAMPLE_W-1:0] smp;
    logic                last;
  } res_word_t;

  class resampler_scoreboard;
    bit                          bypass_on;
    logic [STEP_W-1:0]           step;
    logic signed [SAMPLE_W-1:0]  prev;
    logic [PHASE_W-1:0]          phase;
    bit                          primed;
    res_word_t                   pending[$];
    int                          mismatches;
    int                          checked;

    function void clear();
      bypass_on  = 1'b0;
      step       = STEP_RESET;
      prev       = '0;
      phase      = '0;
      primed     = 1'b0;
      mismatches = 0;
      checked    = 0;
      pending.delete();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_BYPASS) begin
        bypass_on = val[0];
      end else if (idx == CFG_STEP) begin
        step = val[STEP_W-1:0];
      end
    endfunction

    // works out every result word that one accepted input word causes
    function void note_input(logic [SAMPLE_W-1:0] raw);
      logic signed [SAMPLE_W-1:0] cur;
      longint                     diff;
      longint                     prod;
      res_word_t                  w;
      int                         n;
      cur = raw;
      n = 0;
      if (bypass_on) begin
        w.smp  = raw;
        w.last = 1'b1;
        pending.push_back(w);
        return;
      end
      if (!primed) begin
        prev   = cur;
        primed = 1'b1;
        phase  = '0;
        return;
      end
      while (phase < PHASE_ONE && n < MAX_OUT) begin
        diff   = longint'(cur) - longint'(prev);
        prod   = diff * longint'(phase);
        // arithmetic shift floors toward minus infinity
        w.smp  = SAMPLE_W'(longint'(prev) + (prod >>> FRAC_W));
        w.last = 1'b0;
        pending.push_back(w);
        n++;
        phase = phase + PHASE_W'(step);
      end
      if (n > 0) pending[pending.size()-1].last = 1'b1;
      // phase still below one after sixteen words is clamped to zero
      if (phase >= PHASE_ONE) phase = phase - PHASE_ONE;
      else phase = '0;
      prev = cur;
    endfunction

    function void check_result(logic [SAMPLE_W-1:0] smp, logic last);
      res_word_t w;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: unexpected result word sample %h last %b", $realtime, smp, last);
        return;
      end
      w = pending.pop_front();
      checked++;
      if (w.smp !== smp || w.last !== last) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result %0d mismatch: expected sample %h last %b, got sample %h last %b",
                   $realtime, checked, w.smp, w.last, smp, last);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [15:0]           in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [15:0]           out_tdata;
  logic                  out_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  resampler_scoreboard sb;
  int send_idle;
  int recv_idle;
  int rx_hold;
  int words_sent;
  int settings_used;
  int quiet_cycles;

  linear_interpolation_resampler_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off counted down here
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        rx_hold--;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("tb_linear_interpolation_resampler_unit NOT OK");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [15:0] smp);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    sb.note_input(smp);
    words_sent++;
  endtask

  // drop valid and wait until every predicted word has come back
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [15:0] pick_sample(logic [15:0] last_smp);
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      1, 2:    return 16'($urandom);
      default: return 16'(last_smp + 16'($urandom_range(0, 4095)) - 16'd2048);
    endcase
  endfunction

  initial begin
    logic [15:0]       smp;
    logic [STEP_W-1:0] stp;
    sb = new();
    sb.clear();
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    send_idle    = 21;
    recv_idle    = 63;
    rx_hold      = 0;
    words_sent   = 0;
    settings_used = 0;
    quiet_cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // first word only primes the previous sample; default step of one
    send_word(16'h0000);
    send_word(16'h7fff);
    send_word(16'h8000);
    send_word(16'h7fff);
    settle();
    write_reg(CFG_STEP, CFG_DATA_W'(STEP_ONE_HALF));
    send_word(16'h8000);
    send_word(16'h7fff);
    send_word(16'h8000);
    settle();
    // sixteen words per input, full-scale swings both ways
    write_reg(CFG_STEP, CFG_DATA_W'(STEP_SIXTEENTH));
    send_word(16'h7fff);
    send_word(16'h8000);
    send_word(16'h7fff);
    settle();
    // step below a sixteenth: output count capped, phase clamped
    write_reg(CFG_STEP, CFG_DATA_W'(STEP_TINY));
    send_word(16'h8000);
    send_word(16'h0001);
    settle();
    // step of sixteen: most source words skipped
    write_reg(CFG_STEP, CFG_DATA_W'(STEP_SIXTEEN));
    send_word(16'h1234);
    send_word(16'hffff);
    send_word(16'h7fff);
    send_word(16'h8000);
    settle();
    write_reg(CFG_SPARE_A, CFG_DATA_W'(1));
    write_reg(CFG_SPARE_B, '1);
    send_word(16'h5555);
    send_word(16'haaaa);
    settle();
    write_reg(CFG_BYPASS, CFG_DATA_W'(1));
    send_word(16'h7fff);
    send_word(16'h8000);
    send_word(16'h5555);
    send_word(16'haaaa);
    settle();
    write_reg(CFG_BYPASS, CFG_DATA_W'(0));
    write_reg(CFG_STEP, CFG_DATA_W'(STEP_RESET));

    smp = 16'h0000;
    for (int c = 0; c < CHUNKS; c++) begin
      if (c == CHUNKS / 3) begin
        send_idle = 63;
        recv_idle = 21;
      end else if (c == 2 * CHUNKS / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end
      case ($urandom_range(0, 7))
        0:       stp = STEP_SIXTEENTH;
        1:       stp = STEP_SIXTEEN;
        2:       stp = STEP_RESET;
        3:       stp = STEP_W'($urandom_range(4096, 1048576));
        default: stp = STEP_W'($urandom_range(20000, 200000));
      endcase
      write_reg(CFG_BYPASS, CFG_DATA_W'($urandom_range(0, 7) == 0));
      write_reg(CFG_STEP, CFG_DATA_W'(stp));
      for (int k = 0; k < CHUNK_WORDS; k++) begin
        smp = pick_sample(smp);
        send_word(smp);
        if (c == 5 && k == 10) rx_hold = HOLD_CYCLES;
        if (c == 9 && k == 15) settle();
      end
      settle();
    end

    $display("covered %0d input words, %0d result words checked, %0d register writes",
             words_sent, sb.checked, settings_used);
    $display("steps from below a sixteenth to sixteen, bypass, skipped words, long output stall");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb_linear_interpolation_resampler_unit OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
      $display("tb_linear_interpolation_resampler_unit NOT OK");
    end
    $finish;
  end

endmodule
